// ----- design/ufbd_pkg.sv -----
// shared types and constants for the fractional baud divider search
// used by ufbd_divider and uart_fractional_baud_divider_search; no dependencies
package ufbd_pkg;

    localparam int DIV_W     = 32;
    localparam int DIV_STEPS = 2;

    localparam logic [7:0]  FDR_NONE    = 8'h10;
    localparam logic [3:0]  MAX_DIVADD  = 4'd14;
    localparam logic [3:0]  MAX_MUL     = 4'd15;
    localparam logic [3:0]  FIRST_DV    = 4'd1;
    localparam logic [3:0]  FIRST_MV    = 4'd2;
    localparam logic [DIV_W-1:0] MIN_DIVISOR = DIV_W'(3);
    localparam logic [15:0] DIVISOR_MAX = 16'hFFFF;
    // one above the limit, so the final saturation flags it
    localparam logic [DIV_W-1:0] ZERO_BAUD_DL = DIV_W'(32'h0001_0000);

    typedef struct packed {
        logic [26:0] clock_hz;
        logic [22:0] baud;
        logic        fractional_enable;
    } t_in;

    typedef struct packed {
        logic [15:0] divisor;
        logic [7:0]  fraction_byte;
        logic        status;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLAIN_WAIT,
        S_BASE_WAIT,
        S_BEST_WAIT,
        S_PAIR_SETUP,
        S_CAND_START,
        S_CAND_WAIT,
        S_RATE_START,
        S_RATE_WAIT,
        S_NEXT,
        S_FINISH
    } t_state;

    function automatic logic [DIV_W-1:0] abs_diff(input logic [DIV_W-1:0] a,
                                                  input logic [DIV_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ----- design/ufbd_divider.sv -----
// shared unsigned restoring divider, DIV_STEPS quotient bits per cycle
// depends on ufbd_pkg for widths and request/response structs
module ufbd_divider
    import ufbd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int ITER  = DIV_W / DIV_STEPS;
    localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ITER - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W-1:0] n_quo;

    always_comb begin
        logic [DIV_W:0] t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t     = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t        = t - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = t[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator shifts out of r_quo as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- design/uart_fractional_baud_divider_search.sv -----
// top level: sequencer for the baud divider search plus the output register
// depends on ufbd_pkg and ufbd_divider
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries clock_hz, baud and
//   fractional_enable; output channel o_out_valid / i_out_ready carries
//   divisor, fraction_byte and status. One result per input transaction.
//   All divisions run through one shared divider that produces two quotient
//   bits per cycle. Zero baud needs no division; plain mode and fractional
//   mode with an exact divisor need one; otherwise the search runs over 105
//   divider pairs of two divisions each, the second skipped when a candidate
//   divisor falls below 3.
//   The block takes one transaction at a time: o_in_ready is high only while
//   the sequencer is idle. A finished result sits in the output register; if
//   the receiver stalls, the next transaction is still taken and computed,
//   and its result waits in the sequencer until the output register frees.
//   Reset is synchronous active low; it empties the output register and
//   returns the sequencer to idle. There is no memory to clear.
module uart_fractional_baud_divider_search
    import ufbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_state           r_state, n_state;
    logic [26:0]      r_clk, n_clk;
    logic [22:0]      r_br, n_br;
    logic [DIV_W-1:0] r_dl, n_dl;
    logic [7:0]       r_fdr, n_fdr;
    logic [DIV_W-1:0] r_best, n_best;
    logic [DIV_W-1:0] r_cand, n_cand;
    logic [3:0]       r_dv, n_dv;
    logic [3:0]       r_mv, n_mv;
    logic [DIV_W-1:0] r_prod, n_prod;
    logic [DIV_W-1:0] r_den, n_den;
    logic             r_out_valid, n_out_valid;
    t_out             r_out_data, n_out_data;

    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic [4:0]       w_sum;
    logic [DIV_W-1:0] w_br;

    ufbd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign w_sum = 5'(r_mv) + 5'(r_dv);
    assign w_br  = DIV_W'(r_br);

    always_comb begin
        logic [DIV_W-1:0] err;
        n_state     = r_state;
        n_clk       = r_clk;
        n_br        = r_br;
        n_dl        = r_dl;
        n_fdr       = r_fdr;
        n_best      = r_best;
        n_cand      = r_cand;
        n_dv        = r_dv;
        n_mv        = r_mv;
        n_prod      = r_prod;
        n_den       = r_den;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_out_ready;
        div_req     = '0;
        err         = abs_diff(div_rsp.quo, w_br);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_clk = i_in_data.clock_hz;
                    n_br  = i_in_data.baud;
                    n_fdr = FDR_NONE;
                    if (i_in_data.baud == '0) begin
                        n_dl    = ZERO_BAUD_DL;
                        n_state = S_FINISH;
                    end else if (!i_in_data.fractional_enable) begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_W'(i_in_data.clock_hz >> 4)
                                      + DIV_W'(i_in_data.baud >> 1);
                        div_req.den   = DIV_W'(i_in_data.baud);
                        n_state       = S_PLAIN_WAIT;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_W'(i_in_data.clock_hz)
                                      + (DIV_W'(i_in_data.baud) << 3);
                        div_req.den   = DIV_W'(i_in_data.baud) << 4;
                        n_state       = S_BASE_WAIT;
                    end
                end
            end
            S_PLAIN_WAIT: begin
                if (div_rsp.done) begin
                    n_dl    = div_rsp.quo;
                    n_state = S_FINISH;
                end
            end
            S_BASE_WAIT: begin
                if (div_rsp.done) begin
                    n_dl = div_rsp.quo;
                    n_dv = FIRST_DV;
                    n_mv = FIRST_MV;
                    // remainder of half a step means the plain divisor is exact
                    if (div_rsp.rem == (w_br << 3)) begin
                        n_state = S_FINISH;
                    end else if (div_rsp.quo == '0) begin
                        n_best  = w_br;
                        n_state = S_PAIR_SETUP;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = DIV_W'(r_clk >> 4);
                        div_req.den   = div_rsp.quo;
                        n_state       = S_BEST_WAIT;
                    end
                end
            end
            S_BEST_WAIT: begin
                if (div_rsp.done) begin
                    n_best  = err;
                    n_state = S_PAIR_SETUP;
                end
            end
            S_PAIR_SETUP: begin
                n_prod  = DIV_W'(r_clk) * DIV_W'(r_mv);
                n_den   = (w_br << 4) * DIV_W'(w_sum);
                n_state = S_CAND_START;
            end
            S_CAND_START: begin
                div_req.start = 1'b1;
                div_req.num   = r_prod + (r_den >> 1);
                div_req.den   = r_den;
                n_state       = S_CAND_WAIT;
            end
            S_CAND_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quo >= MIN_DIVISOR) begin
                        n_cand  = div_rsp.quo;
                        n_den   = (div_rsp.quo << 4) * DIV_W'(w_sum);
                        n_state = S_RATE_START;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_RATE_START: begin
                div_req.start = 1'b1;
                div_req.num   = r_prod;
                div_req.den   = r_den;
                n_state       = S_RATE_WAIT;
            end
            S_RATE_WAIT: begin
                if (div_rsp.done) begin
                    if (err < r_best) begin
                        n_best = err;
                        n_dl   = r_cand;
                        n_fdr  = {r_mv, r_dv};
                    end
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_mv == MAX_MUL) begin
                    if (r_dv == MAX_DIVADD) begin
                        n_state = S_FINISH;
                    end else begin
                        n_dv    = r_dv + 4'd1;
                        n_mv    = r_dv + 4'd2;
                        n_state = S_PAIR_SETUP;
                    end
                end else begin
                    n_mv    = r_mv + 4'd1;
                    n_state = S_PAIR_SETUP;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_data.fraction_byte = r_fdr;
                    if (r_dl == '0) begin
                        n_out_data.divisor = '0;
                        n_out_data.status  = 1'b1;
                    end else if (r_dl > DIV_W'(DIVISOR_MAX)) begin
                        n_out_data.divisor = DIVISOR_MAX;
                        n_out_data.status  = 1'b1;
                    end else begin
                        n_out_data.divisor = r_dl[15:0];
                        n_out_data.status  = 1'b0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clk      <= n_clk;
        r_br       <= n_br;
        r_dl       <= n_dl;
        r_fdr      <= n_fdr;
        r_best     <= n_best;
        r_cand     <= n_cand;
        r_dv       <= n_dv;
        r_mv       <= n_mv;
        r_prod     <= n_prod;
        r_den      <= n_den;
        r_out_data <= n_out_data;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- test/uart_fractional_baud_divider_search_tb.sv -----
`timescale 1ns / 100ps
// testbench for uart_fractional_baud_divider_search: directed and random divisor requests,
// each result checked against a behavioral divider search; depends on ufbd_pkg and the rtl
module uart_fractional_baud_divider_search_tb
    import ufbd_pkg::*;
();

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 130;
    localparam int IDLE_LIMIT    = 60000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_AFTER    = 30;
    localparam int HOLD_CYCLES   = 12000;
    localparam logic [63:0] OVERSAMPLE = 64'd16;

    typedef struct {
        t_in req;
        bit  drain_first;
    } t_request;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data  = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    t_request    pending_requests[$];
    t_out        expected_settings[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned plain_count    = 0;
    int unsigned frac_count     = 0;
    int unsigned idle_cycles    = 0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          run_left       = 0;
    int          stall_left     = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;

    uart_fractional_baud_divider_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [63:0] rate_gap(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // exact search over all divaddval / mulval pairs, 64-bit arithmetic
    function automatic t_out compute_divider_settings(input t_in req);
        logic [63:0] pclk;
        logic [63:0] target;
        logic [63:0] latch;
        logic [63:0] rounded;
        logic [63:0] best_err;
        logic [63:0] den;
        logic [63:0] cand;
        logic [63:0] got_rate;
        logic [63:0] err;
        logic [7:0]  fdr;
        t_out        res;
        pclk   = 64'(req.clock_hz);
        target = 64'(req.baud);
        fdr    = FDR_NONE;
        res.status = 1'b0;
        if (target == 0) begin
            res.divisor       = DIVISOR_MAX;
            res.fraction_byte = FDR_NONE;
            res.status        = 1'b1;
            return res;
        end
        if (!req.fractional_enable) begin
            latch = (pclk / OVERSAMPLE + target / 2) / target;
        end else begin
            rounded = (pclk + 8 * target) / (OVERSAMPLE * target);
            latch   = rounded;
            if (rounded * target * OVERSAMPLE != pclk) begin
                best_err = (rounded != 0) ? rate_gap(pclk / OVERSAMPLE / rounded, target)
                                          : target;
                for (int dv = 1; dv <= int'(MAX_DIVADD); dv++) begin
                    for (int mv = dv + 1; mv <= int'(MAX_MUL); mv++) begin
                        den  = OVERSAMPLE * target * 64'(mv + dv);
                        cand = (pclk * 64'(mv) + den / 2) / den;
                        if (cand >= 64'(MIN_DIVISOR)) begin
                            got_rate = pclk * 64'(mv) / (OVERSAMPLE * cand * 64'(mv + dv));
                            err      = rate_gap(got_rate, target);
                            // first strictly better pair wins
                            if (err < best_err) begin
                                best_err = err;
                                latch    = cand;
                                fdr      = {4'(mv), 4'(dv)};
                            end
                        end
                    end
                end
            end
        end
        if (latch == 0) begin
            res.status = 1'b1;
        end else if (latch > 64'(DIVISOR_MAX)) begin
            latch      = 64'(DIVISOR_MAX);
            res.status = 1'b1;
        end
        res.divisor       = latch[15:0];
        res.fraction_byte = fdr;
        return res;
    endfunction

    task automatic queue_request(input logic [26:0] pclk, input logic [22:0] target,
                                 input logic frac, input bit drain_first);
        t_request r;
        r.req.clock_hz          = pclk;
        r.req.baud              = target;
        r.req.fractional_enable = frac;
        r.drain_first           = drain_first;
        pending_requests.push_back(r);
    endtask

    task automatic queue_random_request(input bit drain_first);
        logic [26:0] pclk;
        logic [22:0] target;
        int unsigned common_rates[14];
        int          pick;
        common_rates = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600, 115200,
                         230400, 460800, 921600, 1000000, 3000000};
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            pclk = 27'($urandom_range(1000000, 100000000));
        else if (pick <= 7)
            pclk = 27'($urandom);
        else if (pick == 8)
            pclk = 27'($urandom_range(0, 4000));
        else
            pclk = 27'($urandom_range(16, 2000000));
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            target = 23'(common_rates[$urandom_range(0, 13)]);
        else if (pick <= 6)
            target = 23'($urandom_range(1, 6250000));
        else if (pick == 7)
            target = 23'($urandom);
        else if (pick == 8)
            target = 23'($urandom_range(1, 50));
        else
            target = ($urandom_range(0, 3) == 0) ? 23'd0 : 23'($urandom_range(1, 1000));
        queue_request(pclk, target, ($urandom_range(0, 9) < 6), drain_first);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk) begin
        t_request next_req;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_settings.push_back(compute_divider_settings(in_data));
                if (in_data.fractional_enable)
                    frac_count++;
                else
                    plain_count++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_requests.size() > 0 &&
                             (!pending_requests[0].drain_first ||
                              expected_settings.size() == 0)) begin
                    next_req = pending_requests.pop_front();
                    in_data  <= next_req.req;
                    in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 6);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result transaction and drives its own stall pattern
    always @(posedge clk) begin
        t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_settings.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result divisor %0d fraction_byte 0x%02h status %0d",
                             $time, out_data.divisor, out_data.fraction_byte, out_data.status);
                end else begin
                    want = expected_settings.pop_front();
                    if (out_data.divisor !== want.divisor) begin
                        mismatch_count++;
                        $display("%0t: divisor expected %0d actual %0d",
                                 $time, want.divisor, out_data.divisor);
                    end
                    if (out_data.fraction_byte !== want.fraction_byte) begin
                        mismatch_count++;
                        $display("%0t: fraction_byte expected 0x%02h actual 0x%02h",
                                 $time, want.fraction_byte, out_data.fraction_byte);
                    end
                    if (out_data.status !== want.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_data.status);
                    end
                end
            end
            // one long hold so the block backs up and stalls its input
            if (!hold_done && results_seen == HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left   = $urandom_range(1, 40);
                    stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("uart_fractional_baud_divider_search_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // zero baud in both modes
        queue_request(27'd12000000, 23'd0, 1'b0, 1'b0);
        queue_request(27'd12000000, 23'd0, 1'b1, 1'b0);
        // zero divisor
        queue_request(27'd0, 23'd9600, 1'b0, 1'b0);
        queue_request(27'd15, 23'd1, 1'b0, 1'b0);
        queue_request(27'd1, 23'd1, 1'b1, 1'b0);
        // zero rounded divisor in fractional mode
        queue_request(27'd1000, 23'd6250000, 1'b1, 1'b0);
        // exact divisor skips the search
        queue_request(27'd14745600, 23'd9600, 1'b1, 1'b0);
        queue_request(27'd100000000, 23'd6250000, 1'b1, 1'b0);
        // saturation
        queue_request(27'd100000000, 23'd1, 1'b0, 1'b0);
        queue_request(27'd100000000, 23'd1, 1'b1, 1'b0);
        queue_request(27'd100000001, 23'd1, 1'b1, 1'b0);
        // field extremes
        queue_request(27'h7FFFFFF, 23'h7FFFFF, 1'b0, 1'b0);
        queue_request(27'h7FFFFFF, 23'h7FFFFF, 1'b1, 1'b0);
        queue_request(27'h7FFFFFF, 23'd1, 1'b0, 1'b0);
        queue_request(27'd1, 23'h7FFFFF, 1'b1, 1'b0);
        // typical rates
        queue_request(27'd12000000, 23'd115200, 1'b1, 1'b0);
        queue_request(27'd12000000, 23'd115200, 1'b0, 1'b0);
        queue_request(27'd48000000, 23'd9600, 1'b1, 1'b0);
        queue_request(27'd25000000, 23'd115200, 1'b1, 1'b0);
        queue_request(27'd72000000, 23'd3000000, 1'b1, 1'b0);
        queue_request(27'd50000000, 23'd921600, 1'b0, 1'b0);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queue_random_request(n == 0 || n == 80);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_settings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("checked %0d results: %0d plain and %0d fractional requests, %0d mismatches",
                 results_seen, plain_count, frac_count, mismatch_count);
        if (mismatch_count == 0)
            $display("uart_fractional_baud_divider_search_tb passed");
        else
            $display("uart_fractional_baud_divider_search_tb failed");
        $finish;
    end

endmodule
